/* rtl/hla_pkg.sv */
// Shared constants, types and the Q1.14 sine table for the Hough line accumulator.
// No dependencies; imported by hough_line_accumulator.
`default_nettype none

package hla_pkg;

   // Geometry of the vote store
   localparam int THETA_BINS = 180;
   localparam int THETA_W    = 8;
   localparam int RHO_BINS   = 2048;
   localparam int RHO_W      = 11;
   localparam int ADDR_W     = THETA_W + RHO_W;
   localparam int STORE_DEPTH = THETA_BINS * RHO_BINS;

   // Fields and counters
   localparam int COORD_BITS = 10;
   localparam int COUNT_BITS = 16;
   localparam int LIMIT_W    = 12;
   localparam int THRESH_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int Q_SHIFT    = 14;
   localparam int TRIG_W     = 16;  // signed Q1.14
   localparam int PROD_W     = COORD_BITS + 1 + TRIG_W;
   localparam int SUM_W      = PROD_W + 1;

   // Line buffer
   localparam int MAX_LINES  = 64;
   localparam int LINE_IDX_W = 6;
   localparam int LINE_CNT_W = 7;

   // Register indexes
   localparam logic CSR_RHO_LIMIT = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam logic [LIMIT_W-1:0]  RHO_LIMIT_RESET = 12'd1448;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd200;

   typedef struct packed {
      logic [RHO_W-1:0]      rho;
      logic [THETA_W-1:0]    theta;
      logic [COUNT_BITS-1:0] votes;
   } line_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_q;
      logic signed [TRIG_W-1:0] cos_q;
   } trig_type;

   // round(16384 * sin(k degrees)), k = 0..90
   function automatic logic [14:0] quarter_sine(input logic [6:0] k);
      logic [14:0] v;
      unique case (k)
         7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
         7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
         7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
         7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
         7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
         7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
         7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
         7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
         7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
         7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
         7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
         7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
         7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
         7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
         7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
         7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
         7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
         7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
         7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
         7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
         7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
         7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
         7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
         7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
         7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
         7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
         7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
         7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
         7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
         7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
         7'd90: v = 15'd16384;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // sin and cos of a whole-degree angle in 0..179
   function automatic trig_type theta_trig(input logic [THETA_W-1:0] t);
      trig_type    r;
      logic [THETA_W-1:0] s_idx;
      logic [THETA_W-1:0] c_idx;
      logic        upper;
      upper = (t > 8'd90);
      s_idx = upper ? (8'd180 - t) : t;
      c_idx = upper ? (t - 8'd90) : (8'd90 - t);
      r.sin_q = $signed({1'b0, quarter_sine(s_idx[6:0])});
      r.cos_q = upper ? -$signed({1'b0, quarter_sine(c_idx[6:0])})
                      :  $signed({1'b0, quarter_sine(c_idx[6:0])});
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/hough_line_accumulator.sv */
// Hough line accumulator top level: vote pipeline, vote store, peak scan and line buffer.
// Depends on hla_pkg.
`default_nettype none

// Each accepted pixel word with foreground set is voted at all 180 angles, one
// angle per cycle through the single read-modify-write path of the vote store; the
// next pixel may be taken while the last angle is stepped. A background pixel
// without last_pixel casts no votes. The word that carries last_pixel drains the
// vote pipeline, then sweeps the whole store of 180 x 2048 = 368640 counters,
// reading each counter, collecting up to 64 lines in theta-major order and
// clearing it behind the read. Lines are then shown one word at a time, each read
// from the line buffer and held until taken on rsp_ready; a frame with no line
// gives a single word with found low. After reset the store is cleared by the
// same sweep before the first pixel is taken. Configuration writes are taken at
// any time.
module hough_line_accumulator
   import hla_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [COORD_BITS-1:0]  req_x,
   input  wire logic [COORD_BITS-1:0]  req_y,
   input  wire logic                   req_foreground,
   input  wire logic                   req_last_pixel,
   // line channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [RHO_W-1:0]            rsp_rho,
   output logic [THETA_W-1:0]          rsp_theta,
   output logic [COUNT_BITS-1:0]       rsp_votes,
   output logic                        rsp_found,
   output logic                        rsp_last_line,
   output logic                        rsp_overflow,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_VOTE, ST_DRAIN, ST_SCAN, ST_SCAN_END, ST_EMIT_READ, ST_EMIT_SHOW
   } state_type;

   localparam logic [THETA_W-1:0]    THETA_LAST = THETA_W'(THETA_BINS - 1);
   localparam logic [RHO_W-1:0]      RHO_LAST   = RHO_W'(RHO_BINS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic signed [SUM_W-1:0] NEG_ONE_Q = -(SUM_W'(1) <<< Q_SHIFT);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [LIMIT_W-1:0]  rho_limit_ff;
   logic [THRESH_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_limit_ff <= RHO_LIMIT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RHO_LIMIT: rho_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
         endcase
      end
   end

   // bins in use and effective threshold
   logic [LIMIT_W-1:0]  bins_used;
   logic [THRESH_W-1:0] thresh_eff;
   assign bins_used  = (rho_limit_ff > LIMIT_W'(RHO_BINS)) ? LIMIT_W'(RHO_BINS) : rho_limit_ff;
   assign thresh_eff = (threshold_ff == '0) ? THRESH_W'(1) : threshold_ff;

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [THETA_W-1:0]     theta_ff, theta_in;       // vote angle
   logic [THETA_W-1:0]     sweep_t_ff, sweep_t_in;   // scan / clear position
   logic [RHO_W-1:0]       sweep_r_ff, sweep_r_in;
   logic                   last_ff, last_in;
   logic [LINE_CNT_W-1:0]  count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [LINE_IDX_W-1:0]  idx_ff, idx_in;
   logic [COORD_BITS-1:0]  x_ff, y_ff;

   // pipeline valid bits
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, sv_ff;

   logic req_acc, rsp_acc, pipe_busy, sweep_end, is_last_word, line_hit;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     d_addr_ff;

   assign req_ready = (state_ff == ST_IDLE) ||
                      ((state_ff == ST_VOTE) && (theta_ff == THETA_LAST) && !last_ff);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT_SHOW);
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign pipe_busy = a_vld_ff || b_vld_ff || c_vld_ff || d_vld_ff;
   assign sweep_end = (sweep_t_ff == THETA_LAST) && (sweep_r_ff == RHO_LAST);
   assign is_last_word = (count_ff == '0) ||
                         ({1'b0, idx_ff} + LINE_CNT_W'(1) == count_ff);

   // scan hit on the word returned from the store
   assign line_hit = sv_ff &&
                     ({1'b0, d_addr_ff[RHO_W-1:0]} < bins_used) &&
                     (rd_data_ff >= thresh_eff);

   // next-state logic
   always_comb begin
      state_in   = state_ff;
      theta_in   = theta_ff;
      sweep_t_in = sweep_t_ff;
      sweep_r_in = sweep_r_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;

      // sweep counters step in clear and scan
      if ((state_ff == ST_CLEAR) || (state_ff == ST_SCAN)) begin
         if (sweep_r_ff == RHO_LAST) begin
            sweep_r_in = '0;
            sweep_t_in = sweep_t_ff + THETA_W'(1);
         end else begin
            sweep_r_in = sweep_r_ff + RHO_W'(1);
         end
      end

      // line collection during scan
      if (line_hit) begin
         if (count_ff < LINE_CNT_W'(MAX_LINES)) begin
            count_in = count_ff + LINE_CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_VOTE: begin
            if (state_ff == ST_VOTE) begin
               theta_in = theta_ff + THETA_W'(1);
               if (theta_ff == THETA_LAST) begin
                  state_in = last_ff ? ST_DRAIN : ST_IDLE;
               end
            end
            if (req_acc) begin
               last_in  = req_last_pixel;
               theta_in = '0;
               if (req_foreground) begin
                  state_in = ST_VOTE;
               end else if (req_last_pixel) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in   = ST_SCAN;
               sweep_t_in = '0;
               sweep_r_in = '0;
               count_in   = '0;
               ovf_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (sweep_end) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_EMIT_READ;
            idx_in   = '0;
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_SHOW;
         end
         ST_EMIT_SHOW: begin
            if (rsp_acc) begin
               if (is_last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + LINE_IDX_W'(1);
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         theta_ff   <= '0;
         sweep_t_ff <= '0;
         sweep_r_ff <= '0;
         last_ff    <= 1'b0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         theta_ff   <= theta_in;
         sweep_t_ff <= sweep_t_in;
         sweep_r_ff <= sweep_r_in;
         last_ff    <= last_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         idx_ff     <= idx_in;
      end
   end

   // pixel coordinates held for the 180 angles
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff <= req_x;
         y_ff <= req_y;
      end
   end

   // ---------------------------------------------------------------
   // Vote pipeline: A table lookup, B multiply, C sum and range check,
   // D store read returns, increment written back
   // ---------------------------------------------------------------
   trig_type                       trig;
   logic signed [TRIG_W-1:0]       a_sin_ff, a_cos_ff;
   logic [THETA_W-1:0]             a_theta_ff, b_theta_ff;
   logic [COORD_BITS-1:0]          a_x_ff, a_y_ff;
   logic signed [PROD_W-1:0]       b_px_ff, b_py_ff;
   logic signed [SUM_W-1:0]        sum;
   logic [SUM_W-Q_SHIFT-1:0]       rho_trunc;
   logic                           rho_ok;
   logic [ADDR_W-1:0]              c_addr_ff;

   assign trig = theta_trig(theta_ff);

   // rho truncated toward zero; a sum in (-1, 0) lands in bin 0
   assign sum       = SUM_W'(b_px_ff) + SUM_W'(b_py_ff);
   assign rho_trunc = sum[SUM_W-1] ? '0 : sum[SUM_W-1:Q_SHIFT];
   assign rho_ok    = (!sum[SUM_W-1] || (sum > NEG_ONE_Q)) &&
                      (rho_trunc < (SUM_W-Q_SHIFT)'(bins_used));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         sv_ff    <= 1'b0;
      end else begin
         a_vld_ff <= (state_ff == ST_VOTE);
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff && rho_ok;
         d_vld_ff <= c_vld_ff;
         sv_ff    <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      a_sin_ff   <= trig.sin_q;
      a_cos_ff   <= trig.cos_q;
      a_theta_ff <= theta_ff;
      a_x_ff     <= x_ff;
      a_y_ff     <= y_ff;
      b_px_ff    <= $signed({1'b0, a_x_ff}) * a_cos_ff;
      b_py_ff    <= $signed({1'b0, a_y_ff}) * a_sin_ff;
      b_theta_ff <= a_theta_ff;
      c_addr_ff  <= {b_theta_ff, rho_trunc[RHO_W-1:0]};
   end

   // ---------------------------------------------------------------
   // Vote store: one read port, one write port, registered read
   // ---------------------------------------------------------------
   logic [COUNT_BITS-1:0] vote_store [0:STORE_DEPTH-1];
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   assign rd_en   = (state_ff == ST_SCAN) || c_vld_ff;
   assign rd_addr = (state_ff == ST_SCAN) ? {sweep_t_ff, sweep_r_ff} : c_addr_ff;

   // write: clear sweep, saturating increment, or clear behind the scan
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = d_addr_ff;
      wr_data = '0;
      priority if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = {sweep_t_ff, sweep_r_ff};
      end else if (d_vld_ff) begin
         wr_en   = 1'b1;
         wr_data = (rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + COUNT_BITS'(1);
      end else if (sv_ff) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vote_store[rd_addr];
      end
      d_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vote_store[wr_addr] <= wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Line buffer: filled during scan, read one word per result
   // ---------------------------------------------------------------
   line_type line_buf [0:MAX_LINES-1];
   line_type line_rd_ff;
   line_type line_wr;

   assign line_wr.rho   = d_addr_ff[RHO_W-1:0];
   assign line_wr.theta = d_addr_ff[ADDR_W-1:RHO_W];
   assign line_wr.votes = rd_data_ff;

   always_ff @(posedge clock) begin
      if (line_hit && (count_ff < LINE_CNT_W'(MAX_LINES))) begin
         line_buf[count_ff[LINE_IDX_W-1:0]] <= line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT_READ) begin
         line_rd_ff <= line_buf[idx_ff];
      end
   end

   // result word; a frame without lines gives an all-zero word marked last
   assign rsp_found     = (count_ff != '0);
   assign rsp_rho       = rsp_found ? line_rd_ff.rho   : '0;
   assign rsp_theta     = rsp_found ? line_rd_ff.theta : '0;
   assign rsp_votes     = rsp_found ? line_rd_ff.votes : '0;
   assign rsp_last_line = is_last_word;
   assign rsp_overflow  = ovf_ff;

endmodule

`default_nettype wire
